>>> rtl/core/u8d_pkg.sv
// u8d_pkg: types and byte-class constants for the utf-8 stream decoder
// no dependencies; imported by the decode core and the top level

package u8d_pkg;

	localparam int unsigned CpWidth  = 31;
	localparam int unsigned LenWidth = 3;

	// lead byte class boundaries
	localparam logic [7:0] ByteCont  = 8'h80;
	localparam logic [7:0] ByteLead2 = 8'hC0;
	localparam logic [7:0] ByteLead3 = 8'hE0;
	localparam logic [7:0] ByteLead4 = 8'hF0;
	localparam logic [7:0] ByteLead5 = 8'hF8;
	localparam logic [7:0] ByteLead6 = 8'hFC;
	localparam logic [7:0] ContMask  = 8'h3F;

	// top two bits of a continuation byte
	localparam logic [1:0] ContTag = 2'b10;

	// sequence lengths
	localparam logic [LenWidth-1:0] Len1 = 3'd1;
	localparam logic [LenWidth-1:0] Len2 = 3'd2;
	localparam logic [LenWidth-1:0] Len3 = 3'd3;
	localparam logic [LenWidth-1:0] Len4 = 3'd4;
	localparam logic [LenWidth-1:0] Len5 = 3'd5;
	localparam logic [LenWidth-1:0] Len6 = 3'd6;

	typedef struct packed {
		logic [CpWidth-1:0]  code_point;
		logic [LenWidth-1:0] seq_len;
		logic                error;
	} u8d_result_t;

endpackage

>>> rtl/core/u8d_in_if.sv
// u8d_in_if: byte channel into the decoder, valid/ready handshake
// no dependencies

interface u8d_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

>>> rtl/core/u8d_out_if.sv
// u8d_out_if: decoded code point channel, valid/ready handshake
// no dependencies

interface u8d_out_if;
	logic        valid;
	logic        ready;
	logic [30:0] code_point;
	logic [2:0]  seq_len;
	logic        error;

	modport source (output valid, output code_point, output seq_len, output error, input ready);
	modport sink (input valid, input code_point, input seq_len, input error, output ready);
endinterface

>>> rtl/core/utf8_stream_decoder.sv
// utf8_stream_decoder: one byte per transfer in, one code point per completed sequence out
// datapath: an input transfer fills the input register, then the result register
// throughput: one byte per cycle unless the sink stalls, set by the single input to result pass
// reset: arst_n clears the input stage, decoder state (idle) and the result valid at once
// depends on u8d_pkg, u8d_in_if, u8d_out_if, u8d_in_reg, u8d_core

module utf8_stream_decoder
	import u8d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	u8d_in_if.sink     stream,
	u8d_out_if.source  result
);

	// input stage
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        take;

	// decode outputs
	logic        emit;
	u8d_result_t res;

	// result register
	logic        res_valid_q;
	u8d_result_t res_q;

	// the byte in the input register is decoded when the result register is free
	// or its current result leaves in this same cycle; bytes that emit nothing
	// still wait here, which keeps the control to one condition
	assign take = valid_s1 && (!res_valid_q || result.ready);

	u8d_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.stream   (stream),
		.take     (take),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	// partial code point, bytes due and sequence length live in the core
	u8d_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.fire    (take),
		.byte_s1 (byte_s1),
		.emit    (emit),
		.res     (res)
	);

	// result register: loads on a decoded byte that emits, drains on a transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= emit;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			res_q <= res;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.code_point = res_q.code_point;
	assign result.seq_len    = res_q.seq_len;
	assign result.error      = res_q.error;

`ifndef SYNTHESIS
	// an error result carries no code point and no length
	a_error_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.error) |-> (res_q.code_point == '0 && res_q.seq_len == '0))
		else $error("error result with nonzero payload");

	// a good result always has a length of one to six
	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.error) |-> (res_q.seq_len != '0 && res_q.seq_len <= Len6))
		else $error("bad sequence length");

	// a one-byte result is plain ascii
	a_ascii: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && res_q.seq_len == Len1) |-> (res_q.code_point < CpWidth'(ByteCont)))
		else $error("one-byte result above ascii range");

	// a held result is not overwritten while the sink stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !result.ready) |-> !take)
		else $error("input stage advanced into a stalled result");
`endif

endmodule

>>> rtl/core/u8d_in_reg.sv
// u8d_in_reg: input register stage for the byte stream
// depends on u8d_in_if

module u8d_in_reg (
	input  logic       clk,
	input  logic       arst_n,
	u8d_in_if.sink     stream,
	input  logic       take,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	assign stream.ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (stream.ready) begin
			valid_s1 <= stream.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (stream.valid && stream.ready) begin
			byte_s1 <= stream.in_byte;
		end
	end

endmodule

>>> rtl/core/u8d_core.sv
// u8d_core: decoder state and per-byte update logic
// depends on u8d_pkg

module u8d_core
	import u8d_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        fire,
	input  logic [7:0]  byte_s1,
	output logic        emit,
	output u8d_result_t res
);

	logic [CpWidth-1:0]  partial_q, partial_d;
	logic [LenWidth-1:0] due_q, due_d;
	logic [LenWidth-1:0] len_q, len_d;
	logic                is_cont;
	logic [CpWidth-1:0]  shifted;

	assign is_cont = (byte_s1[7:6] == ContTag);
	assign shifted = {partial_q[CpWidth-7:0], byte_s1[5:0] & ContMask[5:0]};

	always_comb begin
		partial_d = partial_q;
		due_d     = due_q;
		len_d     = len_q;
		emit      = 1'b0;
		res       = '0;
		if (due_q == '0) begin
			if (byte_s1 < ByteCont) begin
				emit           = 1'b1;
				res.code_point = {{(CpWidth-8){1'b0}}, byte_s1};
				res.seq_len    = Len1;
			end else if (byte_s1 < ByteLead2) begin
				emit      = 1'b1;
				res.error = 1'b1;
			end else if (byte_s1 < ByteLead3) begin
				partial_d = {{(CpWidth-5){1'b0}}, byte_s1[4:0]};
				len_d     = Len2;
			end else if (byte_s1 < ByteLead4) begin
				partial_d = {{(CpWidth-4){1'b0}}, byte_s1[3:0]};
				len_d     = Len3;
			end else if (byte_s1 < ByteLead5) begin
				partial_d = {{(CpWidth-3){1'b0}}, byte_s1[2:0]};
				len_d     = Len4;
			end else if (byte_s1 < ByteLead6) begin
				partial_d = {{(CpWidth-2){1'b0}}, byte_s1[1:0]};
				len_d     = Len5;
			end else begin
				partial_d = {{(CpWidth-1){1'b0}}, byte_s1[0]};
				len_d     = Len6;
			end
			if (byte_s1 >= ByteLead2) begin
				due_d = len_d - Len1;
			end
		end else if (!is_cont) begin
			emit      = 1'b1;
			res.error = 1'b1;
			partial_d = '0;
			due_d     = '0;
			len_d     = '0;
		end else if (due_q == Len1) begin
			emit           = 1'b1;
			res.code_point = shifted;
			res.seq_len    = len_q;
			partial_d      = '0;
			due_d          = '0;
			len_d          = '0;
		end else begin
			partial_d = shifted;
			due_d     = due_q - Len1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			partial_q <= '0;
			due_q     <= '0;
			len_q     <= '0;
		end else if (fire) begin
			partial_q <= partial_d;
			due_q     <= due_d;
			len_q     <= len_d;
		end
	end

endmodule
